>>> rtl/core/rrwi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating register window index package
// Request and result types, slot state layout and decode constants shared by
// the rotating register window index block.
// ----------------------------------------------------------------------------
package rrwi_pkg;

  // Request kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_ACCESS = 1'b1;

  // Advance modes carried in bits 3:2 of an access code. Other codes hold.
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_SLIDE = 2'd2;

  // Access slot codes in bits 7:4 of an access code.
  localparam logic [3:0] CODE_DIRECT_LIMIT = 4'd2;
  localparam logic [3:0] CODE_HIGH_FIRST   = 4'd10;
  localparam logic [3:0] CODE_HIGH_LAST    = 4'd12;
  localparam logic [3:0] CODE_HIGH_OFFSET  = 4'd8;

  // Slots below this number carry their own inner window length.
  localparam logic [2:0] INNER_SLOTS = 3'd2;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [31:0] control_word;
    logic [7:0]  register_code;
  } req_t;

  typedef struct packed {
    logic [7:0] register_index;
    logic       slot_error;
  } rsp_t;

  typedef struct packed {
    logic [7:0] window_start;
    logic [7:0] window_end;
    logic [1:0] step_size;
    logic [7:0] inner_start;
    logic [7:0] inner_end;
    logic [7:0] current_index;
  } slot_state_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
  } slot_map_t;

  // Maps an access code onto a slot number; ok is low for unknown codes.
  function automatic slot_map_t map_code(input logic [7:0] code);
    slot_map_t  m;
    logic [3:0] n;
    logic [3:0] d;
    n = code[7:4];
    d = n - CODE_HIGH_OFFSET;
    m.ok  = 1'b0;
    m.idx = 3'd0;
    if (n < CODE_DIRECT_LIMIT) begin
      m.ok  = 1'b1;
      m.idx = n[2:0];
    end else if (n >= CODE_HIGH_FIRST && n <= CODE_HIGH_LAST) begin
      m.ok  = 1'b1;
      m.idx = d[2:0];
    end
    return m;
  endfunction

endpackage

>>> rtl/core/rotating_register_window_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating register window index
// Per-slot rotating windows over a matrix register file, with one index
// lookup and advance per request.
// ----------------------------------------------------------------------------
// The block takes one request every cycle unless a held result stalls it.
// The result of an access request passes through the update stage into the
// output register; write requests load a slot and give no result. All slot
// state lives in one small memory with a registered read port: a request
// reads its slot when it is accepted, and in the update stage the slot is
// updated and written back while the result is loaded into the output
// register. A request that reads the slot being written in the same cycle
// receives the new value through a bypass, so requests to the same slot may
// follow each other back to back. Throughput is one request per cycle,
// limited only by the single read-modify-write pass through the slot memory;
// a held result holds an access request in the update stage and, behind it,
// the request side. After reset every slot reads as all zeros at once, since
// each entry has a valid bit that reset clears; there is no clearing pass.
module rotating_register_window_index #(
  parameter int NUM_MATRIX_REGS = 128,
  parameter int NUM_SLOTS       = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rrwi_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rrwi_pkg::rsp_t rsp
);
  import rrwi_pkg::*;

  localparam int          SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [7:0]  NMR    = 8'(NUM_MATRIX_REGS);
  localparam logic [2:0]  NSLOTS = 3'(NUM_SLOTS);

  // Slot memory and its per-entry valid bits.
  slot_state_t            mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   entry_valid;

  // Update stage registers.
  logic                   s1_valid;
  req_t                   s1_req;
  logic                   s1_ok;
  logic [SLOT_W-1:0]      s1_addr;
  slot_state_t            rd_entry;

  // Request decode.
  slot_map_t              map;
  logic                   req_fire;
  logic                   s1_move;
  logic [SLOT_W-1:0]      rd_addr;

  // Write-back.
  logic                   mem_we;
  slot_state_t            wr_entry;
  logic                   s1_result;
  rsp_t                   rsp_next;
  logic                   rsp_valid_next;

  always_comb begin
    map      = map_code(req.register_code);
    map.ok   = map.ok && (map.idx < NSLOTS);
    rd_addr  = (req.kind == KIND_ACCESS) ? map.idx[SLOT_W-1:0] : req.slot[SLOT_W-1:0];
  end

  // The update stage moves unless it holds a result that the output cannot take.
  assign s1_result = s1_valid && (s1_req.kind == KIND_ACCESS);
  assign s1_move   = !s1_result || !rsp_valid || !rsp_stall;
  assign req_stall = !s1_move;
  assign req_fire  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= req_fire;
    end
  end

  // Request payload and the registered read with bypass from the write port.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req  <= req;
      s1_ok   <= (req.kind == KIND_ACCESS) ? map.ok : (req.slot < NSLOTS);
      s1_addr <= rd_addr;
      if (mem_we && s1_addr == rd_addr) begin
        rd_entry <= wr_entry;
      end else if (entry_valid[rd_addr]) begin
        rd_entry <= mem[rd_addr];
      end else begin
        rd_entry <= '0;
      end
    end
  end

  // Next slot state for a write or an advancing access.
  always_comb begin
    logic [7:0] start;
    logic [7:0] st;
    logic [7:0] c;
    logic [7:0] is_v;
    logic [7:0] ie_v;
    logic [1:0] mode;
    start    = {1'b0, s1_req.control_word[6:0]};
    st       = {6'd0, rd_entry.step_size};
    mode     = s1_req.register_code[3:2];
    wr_entry = rd_entry;
    mem_we   = 1'b0;
    c        = rd_entry.current_index + st;
    is_v     = rd_entry.inner_start + st;
    ie_v     = rd_entry.inner_end + st;
    if (s1_req.kind == KIND_WRITE) begin
      wr_entry.window_start  = start;
      wr_entry.step_size     = s1_req.control_word[9:8];
      wr_entry.window_end    = start + s1_req.control_word[31:24];
      wr_entry.inner_start   = start;
      wr_entry.current_index = start;
      if (s1_req.slot < INNER_SLOTS) begin
        wr_entry.inner_end = start + {1'b0, s1_req.control_word[18:12]};
      end else begin
        wr_entry.inner_end = wr_entry.window_end;
      end
      mem_we = s1_valid && s1_move && s1_ok;
    end else if (mode == MODE_STEP) begin
      if (c >= NMR) begin
        c = c - NMR;
      end
      if (c == rd_entry.inner_end) begin
        c = rd_entry.inner_start;
      end
      if (c == rd_entry.window_end) begin
        c = rd_entry.window_start;
      end
      wr_entry.current_index = c;
      mem_we = s1_valid && s1_move && s1_ok;
    end else if (mode == MODE_SLIDE) begin
      if (is_v >= NMR) begin
        is_v = is_v - NMR;
      end
      if (is_v == rd_entry.window_end) begin
        is_v = rd_entry.window_start;
      end
      if (ie_v >= NMR) begin
        ie_v = ie_v - NMR;
      end
      if (ie_v > rd_entry.window_end) begin
        ie_v = rd_entry.window_start + st;
      end
      wr_entry.inner_start   = is_v;
      wr_entry.inner_end     = ie_v;
      wr_entry.current_index = is_v;
      mem_we = s1_valid && s1_move && s1_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  // Output register: the index before any advance, or zero with the error flag.
  always_comb begin
    rsp_next.slot_error     = !s1_ok;
    rsp_next.register_index = s1_ok ? rd_entry.current_index : 8'd0;
    if (s1_result && s1_move) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_result && s1_move) begin
      rsp <= rsp_next;
    end
  end

  // A new result only appears after an access request left the update stage.
  a_rsp_from_access: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(s1_valid && s1_req.kind == KIND_ACCESS))
    else $error("result appeared without an access request");

  // A flagged request never reports an index.
  a_err_zero_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.slot_error) |-> (rsp.register_index == 8'd0))
    else $error("error result carries a nonzero index");

  // A held access request must not update its slot.
  a_no_write_when_held: assert property (@(posedge clk) disable iff (rst)
    (s1_result && rsp_valid && rsp_stall) |-> !mem_we)
    else $error("slot written while its result is held");

  // A stalled result side leaves the held result unchanged.
  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("held result changed");

endmodule

>>> bench/rotating_register_window_index_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating register window index testbench
// Drives write and access requests into the block with random idling on both
// sides. A scoreboard keeps its own copy of every slot window, works out the
// index each access should return, and compares results in order.
// ----------------------------------------------------------------------------
module rotating_register_window_index_test;
  import rrwi_pkg::*;

  localparam int NUM_MATRIX_REGS = 128;
  localparam int NUM_SLOTS       = 5;

  // Access modes that leave the slot as it is.
  localparam logic [1:0] MODE_HOLD     = 2'd0;
  localparam logic [1:0] MODE_HOLD_ALT = 2'd3;

  // Top slot code, which maps to no slot.
  localparam logic [3:0] CODE_ALL_ONES = 4'hF;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shared between the request side and the result side.
  bit hold_output = 1'b0;
  bit steady_flow = 1'b0;
  int items_sent  = 0;

  rotating_register_window_index #(
    .NUM_MATRIX_REGS(NUM_MATRIX_REGS),
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Keeps a shadow of every slot and the queue of indexes still to come back.
  class window_scoreboard;
    rsp_t        expected_results[$];
    slot_state_t slots[NUM_SLOTS];
    int          mismatch_count;

    function new();
      foreach (slots[i]) slots[i] = '0;
      mismatch_count = 0;
    endfunction

    // A single pass of the register count is taken off, never more.
    function logic [7:0] reduce_index(input logic [7:0] v);
      return (v >= NUM_MATRIX_REGS) ? 8'(v - NUM_MATRIX_REGS) : v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(input req_t r);
      slot_state_t st;
      rsp_t        answer;
      logic [7:0]  step8;
      logic [7:0]  sum;
      logic [7:0]  next_start;
      logic [7:0]  next_end;
      logic [3:0]  slot_code;
      int          s;
      bit          ok;

      if (r.kind == KIND_WRITE) begin
        // Writes to slots that do not exist are dropped without a result.
        if (r.slot < NUM_SLOTS) begin
          st.window_start  = {1'b0, r.control_word[6:0]};
          st.step_size     = r.control_word[9:8];
          st.window_end    = st.window_start + r.control_word[31:24];
          st.inner_end     = (r.slot < INNER_SLOTS) ?
                             st.window_start + {1'b0, r.control_word[18:12]} :
                             st.window_end;
          st.inner_start   = st.window_start;
          st.current_index = st.window_start;
          slots[r.slot]    = st;
        end
        return;
      end

      slot_code = r.register_code[7:4];
      ok = 1'b1;
      s  = 0;
      if (slot_code < CODE_DIRECT_LIMIT) begin
        s = int'(slot_code);
      end else if (slot_code >= CODE_HIGH_FIRST && slot_code <= CODE_HIGH_LAST) begin
        s = int'(slot_code) - int'(CODE_HIGH_OFFSET);
      end else begin
        ok = 1'b0;
      end
      if (ok && s >= NUM_SLOTS) ok = 1'b0;

      if (!ok) begin
        answer.register_index = '0;
        answer.slot_error     = 1'b1;
        expected_results.push_back(answer);
        return;
      end

      st    = slots[s];
      step8 = {6'd0, st.step_size};
      answer.register_index = st.current_index;
      answer.slot_error     = 1'b0;

      case (r.register_code[3:2])
        MODE_STEP: begin
          sum = st.current_index + step8;
          sum = reduce_index(sum);
          if (sum == st.inner_end) sum = st.inner_start;
          if (sum == st.window_end) sum = st.window_start;
          st.current_index = sum;
        end
        MODE_SLIDE: begin
          sum = st.inner_start + step8;
          next_start = reduce_index(sum);
          if (next_start == st.window_end) next_start = st.window_start;
          sum = st.inner_end + step8;
          next_end = reduce_index(sum);
          if (next_end > st.window_end) next_end = st.window_start + step8;
          st.inner_start   = next_start;
          st.inner_end     = next_end;
          st.current_index = next_start;
        end
        default: begin
        end
      endcase
      slots[s] = st;
      expected_results.push_back(answer);
    endfunction

    function void check_result(input rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: index %0d error %0b",
                   got.register_index, got.slot_error);
        return;
      end
      want = expected_results.pop_front();
      if (got.register_index !== want.register_index ||
          got.slot_error !== want.slot_error) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected index %0d error %0b, got index %0d error %0b",
                   want.register_index, want.slot_error,
                   got.register_index, got.slot_error);
      end
    endfunction
  endclass

  window_scoreboard results = new();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both handshakes are sampled at the rising edge, before any of this
  // edge's updates land, so the order of processes does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) results.check_result(rsp);
      if (req_valid && !req_stall) results.note_request(req);
    end
  end

  // Result side: random stalls, none at all during the steady stretch, and
  // one long hold-off that lets the block fill up and push back.
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (hold_output) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      rsp_stall <= !steady_flow && ($urandom_range(99) < 30);
    end
  end

  // Ends the run when neither side has moved for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("rotating_register_window_index test failed");
    $finish;
  end

  function automatic logic [3:0] code_for_slot(input int s);
    logic [3:0] c;
    c = 4'(s);
    if (s >= CODE_DIRECT_LIMIT) c = c + CODE_HIGH_OFFSET;
    return c;
  endfunction

  // Unused fields carry random bits so that every input bit toggles.
  function automatic req_t make_write(input int s, input logic [31:0] word);
    req_t r;
    r.kind          = KIND_WRITE;
    r.slot          = 3'(s);
    r.control_word  = word;
    r.register_code = 8'($urandom);
    return r;
  endfunction

  function automatic req_t make_access(input logic [3:0] slot_code,
                                       input logic [1:0] mode);
    req_t r;
    r.kind          = KIND_ACCESS;
    r.slot          = 3'($urandom);
    r.control_word  = $urandom;
    r.register_code = {slot_code, mode, 2'($urandom_range(3))};
    return r;
  endfunction

  function automatic logic [31:0] build_word(input int start, input int step,
                                             input int inner, input int outer);
    logic [31:0] w;
    w = $urandom;
    w[6:0]   = 7'(start);
    w[9:8]   = 2'(step);
    w[18:12] = 7'(inner);
    w[31:24] = 8'(outer);
    return w;
  endfunction

  // Offers one request, idling first at random, and holds it until taken.
  task automatic send_request(input req_t r);
    while (!steady_flow && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (!(r.kind == KIND_WRITE && r.slot >= NUM_SLOTS)) items_sent++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (results.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int         slot_num;
    int         burst;
    int         pick;
    int         roll;
    logic [1:0] mode;
    req_t       r;
    bit         hold_done;
    bit         pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Straight after reset every slot is zero; also every kind of bad code.
    send_request(make_access(code_for_slot(0), MODE_STEP));
    send_request(make_access(CODE_DIRECT_LIMIT, MODE_STEP));
    send_request(make_access(CODE_HIGH_FIRST - 4'd1, MODE_SLIDE));
    send_request(make_access(CODE_HIGH_LAST + 4'd1, MODE_HOLD));
    send_request(make_access(CODE_ALL_ONES, MODE_HOLD_ALT));

    // All-zero and all-ones control words; the latter wraps both ends.
    send_request(make_write(0, 32'h0000_0000));
    send_request(make_access(code_for_slot(0), MODE_STEP));
    send_request(make_write(1, 32'hFFFF_FFFF));
    send_request(make_access(code_for_slot(1), MODE_STEP));
    send_request(make_access(code_for_slot(1), MODE_SLIDE));
    send_request(make_access(code_for_slot(1), MODE_HOLD));

    // The index climbs past the register count and is folded back once.
    send_request(make_write(2, build_word(124, 2, 0, 10)));
    send_request(make_access(code_for_slot(2), MODE_STEP));
    send_request(make_access(code_for_slot(2), MODE_STEP));
    send_request(make_access(code_for_slot(2), MODE_STEP));

    // The index reaches the end of the window and returns to its start.
    send_request(make_write(3, build_word(10, 1, 0, 3)));
    send_request(make_access(code_for_slot(3), MODE_STEP));
    send_request(make_access(code_for_slot(3), MODE_STEP));
    send_request(make_access(code_for_slot(3), MODE_STEP));

    // Sliding moves the inner end past the window end.
    send_request(make_write(4, build_word(0, 3, 0, 4)));
    send_request(make_access(code_for_slot(4), MODE_SLIDE));
    send_request(make_access(code_for_slot(4), MODE_SLIDE));

    // Writes to slot numbers beyond the last slot are dropped.
    send_request(make_write(NUM_SLOTS, 32'hFFFF_FFFF));
    send_request(make_write(7, 32'h0000_0000));

    // A short inner window inside a wider one.
    send_request(make_write(0, build_word(5, 1, 2, 8)));
    send_request(make_access(code_for_slot(0), MODE_STEP));
    send_request(make_access(code_for_slot(0), MODE_SLIDE));

    // Random part: mostly a fresh window followed by a burst of accesses,
    // some bursts on a slot left from earlier, and some plain noise.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        r.kind          = 1'($urandom_range(1));
        r.slot          = 3'($urandom);
        r.control_word  = $urandom;
        r.register_code = 8'($urandom);
        send_request(r);
      end else begin
        slot_num = $urandom_range(NUM_SLOTS - 1);
        if (pick < 80) begin
          if ($urandom_range(3) == 0)
            send_request(make_write(slot_num, $urandom));
          else
            send_request(make_write(slot_num,
              build_word($urandom_range(127), $urandom_range(3),
                         $urandom_range(1) ? $urandom_range(15) : $urandom_range(127),
                         $urandom_range(1) ? $urandom_range(40) : $urandom_range(255))));
        end
        burst = $urandom_range(2, 12);
        repeat (burst) begin
          roll = $urandom_range(99);
          if (roll < 50)
            mode = MODE_STEP;
          else if (roll < 80)
            mode = MODE_SLIDE;
          else if (roll < 90)
            mode = MODE_HOLD;
          else
            mode = MODE_HOLD_ALT;
          if ($urandom_range(9) == 0)
            send_request(make_access(code_for_slot($urandom_range(NUM_SLOTS - 1)), mode));
          else
            send_request(make_access(code_for_slot(slot_num), mode));
        end
      end

      // The result side holds off once while requests keep coming.
      if (!hold_done && items_sent >= 300) begin
        hold_output = 1'b1;
        hold_done   = 1'b1;
      end
      // Once the request side stops until every result is back.
      if (!pause_done && items_sent >= 600) begin
        wait_for_results();
        pause_done = 1'b1;
      end
      steady_flow = (items_sent >= 700 && items_sent < 850);
    end

    steady_flow = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results.pending() != 0)
      $display("%0d expected results never arrived", results.pending());
    if (results.mismatch_count == 0 && results.pending() == 0) begin
      $display("rotating_register_window_index test passed");
    end else begin
      $display("rotating_register_window_index test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rrwi_pkg.sv
rtl/core/rotating_register_window_index.sv
bench/rotating_register_window_index_test.sv
